>>> hw/rtl/roi_pkg.sv
// ----------------------------------------------------------------------------
// roi_pkg: shared constants and types of the ray versus oriented box unit
// Fixed formats, slab parameter range and the sideband record of one item.
// ----------------------------------------------------------------------------
package roi_pkg;

  // Default component width of the packed triples
  localparam int COMPONENT_WIDTH_DEF = 21;

  // Slab parameter magnitude bits (saturates at 2^T_BITS - 1)
  localparam int T_BITS = 40;

  // Fraction bits added to the quotient: 27 - 38 + 19 gives Q.8
  localparam int FRAC_SHIFT = 19;

  // size/2 at 27 fraction bits is size shifted left by this
  localparam int HALF_SHIFT = 18;

  // Reach and epsilon register formats
  localparam int REACH_W = 21;
  localparam int EPS_W   = 19;
  localparam logic [EPS_W-1:0] EPS_RESET = 19'd5;

  // Number of local axes
  localparam int AXES = 3;

  // Per-item sideband that travels beside the dividers
  typedef struct packed {
    logic [AXES-1:0]    par;   // axis counts as parallel
    logic [AXES-1:0]    outs;  // parallel axis with origin outside its slab
    logic [AXES-1:0]    neg1;  // sign of t for the lower bound
    logic [AXES-1:0]    neg2;  // sign of t for the upper bound
    logic [REACH_W-1:0] reach;
  } roi_meta_t;

endpackage

>>> hw/rtl/roi_slab_div.sv
// ----------------------------------------------------------------------------
// roi_slab_div: pipelined slab quotient divider
// Gives min(floor(num * 2^FRAC_SHIFT / den), 2^T_BITS - 1), one quotient bit
// per stage, a new operand pair in every enabled cycle.
// ----------------------------------------------------------------------------
module roi_slab_div
  import roi_pkg::*;
#(
  parameter int NUM_W = 46,
  parameter int DEN_W = 44
) (
  input  logic              clk,
  input  logic              en,
  input  logic [NUM_W-1:0]  num_mag,
  input  logic [DEN_W-1:0]  den_mag,
  output logic [T_BITS-1:0] quot
);

  localparam int SH = T_BITS - FRAC_SHIFT;

  logic [DEN_W-1:0]  den_r  [0:T_BITS-1];
  logic [DEN_W-1:0]  rem_r  [0:T_BITS-1];
  logic [T_BITS-1:0] bits_r [0:T_BITS-1];
  logic [T_BITS-1:0] quo_r  [0:T_BITS];
  logic              ovf_r  [0:T_BITS];

  // Load: high part of the dividend forms the first remainder; the quotient
  // overflows when that part already reaches the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0]  <= den_mag;
      rem_r[0]  <= DEN_W'(num_mag[NUM_W-1:SH]);
      ovf_r[0]  <= DEN_W'(num_mag[NUM_W-1:SH]) >= den_mag;
      bits_r[0] <= {num_mag[SH-1:0], {FRAC_SHIFT{1'b0}}};
      quo_r[0]  <= '0;
    end
  end

  // One restoring step per stage
  for (genvar k = 1; k <= T_BITS; k++) begin : g_step
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    assign trial = {rem_r[k-1], bits_r[k-1][T_BITS-1]};
    assign diff  = trial - {1'b0, den_r[k-1]};
    assign ge    = trial >= {1'b0, den_r[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[k] <= {quo_r[k-1][T_BITS-2:0], ge};
        ovf_r[k] <= ovf_r[k-1];
      end
    end

    if (k < T_BITS) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
          bits_r[k] <= {bits_r[k-1][T_BITS-2:0], 1'b0};
          den_r[k]  <= den_r[k-1];
        end
      end
    end
  end

  // Saturate on overflow
  assign quot = ovf_r[T_BITS] ? {T_BITS{1'b1}} : quo_r[T_BITS];

endmodule

>>> hw/rtl/ray_obb_intersect_unit.sv
// ----------------------------------------------------------------------------
// ray_obb_intersect_unit: ray versus oriented box slab test
// Moves the ray into box space and reports whether it enters within reach.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one ray and one box per
//   transaction; output channel (out_valid / out_stall) returns one hit bit
//   per transaction, in order.
//   The parallel threshold is written through cfg_valid / cfg_ready
//   (cfg_ready is always high); write it only while the unit is empty.
//   From input to out_valid a transaction passes four stages of offset,
//   products, dot sums and slab setup, a divider of T_BITS + 1 stages (a load
//   stage, then one quotient bit each), three stages of interval reduction and
//   the output register.
//   Throughput is one transaction per cycle while in_stall is low, set by the
//   fully pipelined dividers (six in parallel).
//   When the receiver stalls, the output register holds and one more result
//   lands in a skid register; in_stall rises only while that skid is full,
//   and the whole pipeline holds until it drains. Nothing is lost.
//   Reset clears all valid bits and loads the threshold with 5.
// ----------------------------------------------------------------------------
module ray_obb_intersect_unit
  import roi_pkg::*;
#(
  parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [3*COMPONENT_WIDTH-1:0] in_ray_origin,
  input  logic [3*COMPONENT_WIDTH-1:0] in_ray_dir,
  input  logic [3*COMPONENT_WIDTH-1:0] in_box_center,
  input  logic [3*COMPONENT_WIDTH-1:0] in_box_size,
  input  logic [3*COMPONENT_WIDTH-1:0] in_rot_row_zero,
  input  logic [3*COMPONENT_WIDTH-1:0] in_rot_row_one,
  input  logic [3*COMPONENT_WIDTH-1:0] in_rot_row_two,
  input  logic [REACH_W-1:0]           in_reach,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_hit,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [EPS_W-1:0]             cfg_slab_epsilon
);

  localparam int W       = COMPONENT_WIDTH;
  localparam int OFF_W   = W + 1;
  localparam int PL_W    = 2 * W + 1;
  localparam int PD_W    = 2 * W;
  localparam int LO_W    = 2 * W + 3;
  localparam int LD_W    = 2 * W + 2;
  localparam int NUM_W   = 2 * W + 4;
  localparam int EPS_SW  = EPS_W + FRAC_SHIFT;
  localparam int CMP_W   = (LD_W > EPS_SW) ? LD_W : EPS_SW;
  localparam int TW      = T_BITS + 3;
  localparam int DIV_LAT = T_BITS + 1;

  localparam logic signed [TW-1:0] T_UNB = TW'(1) <<< (T_BITS + 1);

  // Configuration
  logic [EPS_W-1:0] eps_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (cfg_valid) begin
      eps_r <= cfg_slab_epsilon;
    end
  end

  // Pipeline enable: hold everything while the skid register is full
  logic en;
  logic skid_valid_r;
  logic skid_hit_r;
  logic out_valid_r;
  logic out_hit_r;

  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  // Stage 1: unpack, form origin offset
  logic [3*W-1:0] rows [AXES];
  assign rows[0] = in_rot_row_zero;
  assign rows[1] = in_rot_row_one;
  assign rows[2] = in_rot_row_two;

  logic                      s1_valid_r;
  logic signed [OFF_W-1:0]   s1_offs_r [AXES];
  logic signed [W-1:0]       s1_dir_r  [AXES];
  logic signed [W-1:0]       s1_size_r [AXES];
  logic signed [W-1:0]       s1_rot_r  [AXES][AXES];
  logic [REACH_W-1:0]        s1_reach_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < AXES; i++) begin
        s1_offs_r[i] <= OFF_W'($signed(in_ray_origin[i*W +: W]))
                      - OFF_W'($signed(in_box_center[i*W +: W]));
        s1_dir_r[i]  <= $signed(in_ray_dir[i*W +: W]);
        s1_size_r[i] <= $signed(in_box_size[i*W +: W]);
        for (int j = 0; j < AXES; j++) begin
          s1_rot_r[i][j] <= $signed(rows[i][j*W +: W]);
        end
      end
      s1_reach_r <= in_reach;
    end
  end

  // Stage 2: products of rotation columns with offset and direction
  logic                     s2_valid_r;
  logic signed [PL_W-1:0]   s2_pl_r [AXES][AXES];
  logic signed [PD_W-1:0]   s2_pd_r [AXES][AXES];
  logic signed [W-1:0]      s2_size_r [AXES];
  logic [REACH_W-1:0]       s2_reach_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < AXES; i++) begin
        for (int j = 0; j < AXES; j++) begin
          s2_pl_r[i][j] <= PL_W'(s1_rot_r[j][i]) * PL_W'(s1_offs_r[j]);
          s2_pd_r[i][j] <= PD_W'(s1_rot_r[j][i]) * PD_W'(s1_dir_r[j]);
        end
        s2_size_r[i] <= s1_size_r[i];
      end
      s2_reach_r <= s1_reach_r;
    end
  end

  // Stage 3: dot product sums
  logic                     s3_valid_r;
  logic signed [LO_W-1:0]   s3_lo_r [AXES];
  logic signed [LD_W-1:0]   s3_ld_r [AXES];
  logic signed [W-1:0]      s3_size_r [AXES];
  logic [REACH_W-1:0]       s3_reach_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < AXES; i++) begin
        s3_lo_r[i] <= LO_W'(s2_pl_r[i][0]) + LO_W'(s2_pl_r[i][1])
                    + LO_W'(s2_pl_r[i][2]);
        s3_ld_r[i] <= LD_W'(s2_pd_r[i][0]) + LD_W'(s2_pd_r[i][1])
                    + LD_W'(s2_pd_r[i][2]);
        s3_size_r[i] <= s2_size_r[i];
      end
      s3_reach_r <= s2_reach_r;
    end
  end

  // Stage 4: slab numerators, magnitudes, parallel and outside tests
  logic signed [NUM_W-1:0] hi_c   [AXES];
  logic signed [NUM_W-1:0] lo_c   [AXES];
  logic signed [NUM_W-1:0] num1_c [AXES];
  logic signed [NUM_W-1:0] num2_c [AXES];
  logic [LD_W-1:0]         ad_c   [AXES];

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      hi_c[i]   = NUM_W'(s3_size_r[i]) <<< HALF_SHIFT;
      lo_c[i]   = NUM_W'(s3_lo_r[i]);
      num1_c[i] = -hi_c[i] - lo_c[i];
      num2_c[i] = hi_c[i] - lo_c[i];
      ad_c[i]   = s3_ld_r[i][LD_W-1] ? LD_W'(-s3_ld_r[i]) : LD_W'(s3_ld_r[i]);
    end
  end

  logic                s4_valid_r;
  logic [NUM_W-1:0]    s4_an1_r [AXES];
  logic [NUM_W-1:0]    s4_an2_r [AXES];
  logic [LD_W-1:0]     s4_ad_r  [AXES];
  roi_meta_t           s4_meta_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < AXES; i++) begin
        s4_an1_r[i] <= num1_c[i][NUM_W-1] ? NUM_W'(-num1_c[i]) : NUM_W'(num1_c[i]);
        s4_an2_r[i] <= num2_c[i][NUM_W-1] ? NUM_W'(-num2_c[i]) : NUM_W'(num2_c[i]);
        s4_ad_r[i]  <= ad_c[i];
        s4_meta_r.par[i]  <= (s3_ld_r[i] == '0)
                           || (CMP_W'(ad_c[i]) < CMP_W'({eps_r, {FRAC_SHIFT{1'b0}}}));
        s4_meta_r.outs[i] <= (lo_c[i] < -hi_c[i]) || (lo_c[i] > hi_c[i]);
        s4_meta_r.neg1[i] <= num1_c[i][NUM_W-1] ^ s3_ld_r[i][LD_W-1];
        s4_meta_r.neg2[i] <= num2_c[i][NUM_W-1] ^ s3_ld_r[i][LD_W-1];
      end
      s4_meta_r.reach <= s3_reach_r;
    end
  end

  // Dividers: two slab parameters per axis
  logic [T_BITS-1:0] q1 [AXES];
  logic [T_BITS-1:0] q2 [AXES];

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    roi_slab_div #(.NUM_W(NUM_W), .DEN_W(LD_W)) u_div_lo (
      .clk     (clk),
      .en      (en),
      .num_mag (s4_an1_r[a]),
      .den_mag (s4_ad_r[a]),
      .quot    (q1[a])
    );
    roi_slab_div #(.NUM_W(NUM_W), .DEN_W(LD_W)) u_div_hi (
      .clk     (clk),
      .en      (en),
      .num_mag (s4_an2_r[a]),
      .den_mag (s4_ad_r[a]),
      .quot    (q2[a])
    );
  end

  // Sideband delay matched to the divider depth
  logic [DIV_LAT-1:0] dv_r;
  roi_meta_t          dm_r [DIV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      dm_r[0] <= s4_meta_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        dm_r[k] <= dm_r[k-1];
      end
    end
  end

  // Stage 5: signed, ordered interval per axis
  logic signed [TW-1:0] t1_c [AXES];
  logic signed [TW-1:0] t2_c [AXES];

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      t1_c[i] = $signed({{(TW-T_BITS){1'b0}}, q1[i]});
      t2_c[i] = $signed({{(TW-T_BITS){1'b0}}, q2[i]});
      if (dm_r[DIV_LAT-1].neg1[i]) begin
        t1_c[i] = -t1_c[i];
      end
      if (dm_r[DIV_LAT-1].neg2[i]) begin
        t2_c[i] = -t2_c[i];
      end
    end
  end

  logic                  s5_valid_r;
  logic signed [TW-1:0]  s5_tlo_r [AXES];
  logic signed [TW-1:0]  s5_thi_r [AXES];
  logic                  s5_out_r;
  logic [REACH_W-1:0]    s5_reach_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < AXES; i++) begin
        if (dm_r[DIV_LAT-1].par[i]) begin
          s5_tlo_r[i] <= -T_UNB;
          s5_thi_r[i] <= T_UNB;
        end else if (t1_c[i] > t2_c[i]) begin
          s5_tlo_r[i] <= t2_c[i];
          s5_thi_r[i] <= t1_c[i];
        end else begin
          s5_tlo_r[i] <= t1_c[i];
          s5_thi_r[i] <= t2_c[i];
        end
      end
      s5_out_r   <= |(dm_r[DIV_LAT-1].par & dm_r[DIV_LAT-1].outs);
      s5_reach_r <= dm_r[DIV_LAT-1].reach;
    end
  end

  // Stage 6: intersect the three intervals
  logic signed [TW-1:0] tmin_c;
  logic signed [TW-1:0] tmax_c;

  always_comb begin
    tmin_c = s5_tlo_r[0];
    tmax_c = s5_thi_r[0];
    for (int i = 1; i < AXES; i++) begin
      if (s5_tlo_r[i] > tmin_c) begin
        tmin_c = s5_tlo_r[i];
      end
      if (s5_thi_r[i] < tmax_c) begin
        tmax_c = s5_thi_r[i];
      end
    end
  end

  logic                  s6_valid_r;
  logic signed [TW-1:0]  s6_tmin_r;
  logic signed [TW-1:0]  s6_tmax_r;
  logic                  s6_out_r;
  logic [REACH_W-1:0]    s6_reach_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_tmin_r  <= tmin_c;
      s6_tmax_r  <= tmax_c;
      s6_out_r   <= s5_out_r;
      s6_reach_r <= s5_reach_r;
    end
  end

  // Stage 7: final decision
  logic signed [TW-1:0] reach_c;
  logic                 p_valid_r;
  logic                 p_hit_r;

  assign reach_c = $signed({{(TW-REACH_W){1'b0}}, s6_reach_r});

  always_ff @(posedge clk) begin
    if (en) begin
      p_hit_r <= !s6_out_r
              && ((s6_tmin_r > 0) || (s6_tmax_r > 0))
              && (s6_tmin_r <= reach_c)
              && (s6_tmin_r <= s6_tmax_r);
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      dv_r       <= '0;
      s5_valid_r <= 1'b0;
      s6_valid_r <= 1'b0;
      p_valid_r  <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      dv_r       <= {dv_r[DIV_LAT-2:0], s4_valid_r};
      s5_valid_r <= dv_r[DIV_LAT-1];
      s6_valid_r <= s5_valid_r;
      p_valid_r  <= s6_valid_r;
    end
  end

  // Output register with skid: take the skid first, else the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= p_valid_r;
      end
    end else if (p_valid_r && !skid_valid_r) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_hit_r <= skid_valid_r ? skid_hit_r : p_hit_r;
    end else if (!skid_valid_r) begin
      skid_hit_r <= p_hit_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

  // Checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while the output register is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_stall) |=> !skid_valid_r)
    else $error("skid did not drain after the output was taken");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> s1_valid_r)
    else $error("accepted transaction missing from the first stage");

  a_skid_needs_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid filled without a stalled output");

endmodule
